// ===== sv/kvt_pkg.sv =====
package kvt_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 128;
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Command codes. Code 3 is unused and behaves as a miss.
    localparam logic [1:0] CMD_PUT = 2'd0;
    localparam logic [1:0] CMD_GET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_HIT      = 3'd3;
    localparam logic [2:0] ST_MISS     = 3'd4;
    localparam logic [2:0] ST_REMOVED  = 3'd5;
    localparam logic [2:0] ST_DEL_MISS = 3'd6;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] search_key;
        logic [63:0] new_value;
    } t_kvt_in;

    // Output transaction payload.
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_value;
        logic [7:0]  entry_count;
        logic        table_empty;
    } t_kvt_out;

    // Request broadcast to every cell while an operation runs.
    typedef struct packed {
        logic [1:0]            cmd;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_kvt_req;

    // Token that walks the chain one cell per cycle.
    typedef struct packed {
        logic                  active;
        logic                  found;
        logic                  done;
        logic [VALUE_BITS-1:0] rd;
    } t_kvt_tok;

    // Contents of one cell.
    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_kvt_entry;

endpackage

// ===== sv/kvt_cell.sv =====
module kvt_cell
    import kvt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_index,
    input  logic [CNT_W-1:0] i_count,
    input  t_kvt_req         i_req,
    input  t_kvt_tok         i_tok,
    output t_kvt_tok         o_tok,
    input  t_kvt_entry       i_right,
    input  logic             i_pull,
    output t_kvt_entry       o_entry,
    output logic             o_pull
);

    t_kvt_entry r_entry;
    t_kvt_entry n_entry;
    t_kvt_tok   r_tok;
    t_kvt_tok   n_tok;
    logic       w_live;
    logic       w_hit;

    // Only cells below the entry count hold live entries.
    assign w_live  = i_index < i_count;
    assign w_hit   = w_live && (r_entry.key == i_req.key);
    assign o_entry = r_entry;
    assign o_tok   = r_tok;
    // Once the deleted entry has been passed, every cell moves one slot down.
    assign o_pull  = i_tok.active && (i_req.cmd == CMD_DEL) && i_tok.found;

    always_comb begin
        n_entry = r_entry;
        n_tok   = i_tok;
        if (i_pull) begin
            n_entry = i_right;
        end else if (i_tok.active) begin
            unique case (i_req.cmd)
                CMD_PUT: begin
                    if (!i_tok.done) begin
                        if (w_hit) begin
                            n_entry.value = i_req.value;
                            n_tok.done    = 1'b1;
                            n_tok.found   = 1'b1;
                        end else if (!w_live) begin
                            n_entry.key   = i_req.key;
                            n_entry.value = i_req.value;
                            n_tok.done    = 1'b1;
                        end
                    end
                end
                CMD_GET: begin
                    if (!i_tok.found && w_hit) begin
                        n_tok.found = 1'b1;
                        n_tok.rd    = r_entry.value;
                    end
                end
                CMD_DEL: begin
                    if (!i_tok.found && w_hit) begin
                        n_tok.found = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

endmodule

// ===== sv/key_value_table_linear_top.sv =====
// Bounded key-value table kept packed in insertion order in a chain of cells.
// The input channel (i_in_valid, o_in_stall, i_in) carries one command per
// transaction: put, get or delete of a key. The output channel (o_out_valid,
// i_out_stall, o_out) returns exactly one result transaction per command with
// a status, the value read by a get, the entry count and an empty flag.
// An accepted command launches a token into cell 0; the token moves one cell
// per cycle down all TABLE_DEPTH cells, updating, inserting or reading as it
// passes. On a delete, every cell behind the match takes its right neighbor's
// contents, which closes the gap. The result is held in a result register
// once the token leaves the last cell and moves to the output register when
// that register is free; the next command is taken once the block is idle
// again, so the walk of the token through the chain bounds the command rate.
// One command is in the chain at a time; o_in_stall is high meanwhile.
// A finished result sits in the output register while a new command is
// accepted; if the receiver stalls, the next result waits in a holding
// register and the input stalls until the output register frees.
// Synchronous reset empties the table and drops any transaction in flight.
module key_value_table_linear_top
    import kvt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_kvt_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_kvt_out o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    t_kvt_req         r_req;
    logic             r_launch;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_kvt_out         r_res;
    t_kvt_out         n_res;
    logic             r_out_valid;
    t_kvt_out         r_out;

    t_kvt_tok         w_tok [TABLE_DEPTH+1];
    t_kvt_entry       w_entry [TABLE_DEPTH];
    logic             w_pull [TABLE_DEPTH];
    logic             w_accept;
    logic             w_out_free;
    logic             w_exit;
    t_kvt_tok         w_tail;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A fresh token enters cell 0 in the cycle after a command is accepted.
    // Its fields are active, found, done and the read value, in that order.
    assign w_tok[0] = {r_launch, 1'b0, 1'b0, {VALUE_BITS{1'b0}}};

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_kvt_entry w_right;
        logic       w_rpull;
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_right = '0;
            assign w_rpull = 1'b0;
        end else begin : g_mid
            assign w_right = w_entry[g+1];
            assign w_rpull = w_pull[g+1];
        end
        kvt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (CNT_W'(g)),
            .i_count (r_count),
            .i_req   (r_req),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_right (w_right),
            .i_pull  (w_rpull),
            .o_entry (w_entry[g]),
            .o_pull  (w_pull[g])
        );
    end

    assign w_tail = w_tok[TABLE_DEPTH];
    assign w_exit = (r_state == S_RUN) && w_tail.active;

    // Turn the flags carried out of the last cell into a result.
    always_comb begin
        n_count          = r_count;
        n_res            = '0;
        n_res.status     = ST_MISS;
        unique case (r_req.cmd)
            CMD_PUT: begin
                if (w_tail.found) begin
                    n_res.status = ST_UPDATED;
                end else if (w_tail.done) begin
                    n_res.status = ST_INSERTED;
                    n_count      = r_count + 1'b1;
                end else begin
                    n_res.status = ST_FULL;
                end
            end
            CMD_GET: begin
                if (w_tail.found) begin
                    n_res.status     = ST_HIT;
                    n_res.read_value = 64'(w_tail.rd);
                end else begin
                    n_res.status = ST_MISS;
                end
            end
            CMD_DEL: begin
                if (w_tail.found) begin
                    n_res.status = ST_REMOVED;
                    n_count      = r_count - 1'b1;
                end else begin
                    n_res.status = ST_DEL_MISS;
                end
            end
            default: begin
                n_res.status = ST_MISS;
            end
        endcase
        n_res.entry_count = 8'(n_count);
        n_res.table_empty = (n_count == '0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_exit) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.cmd   <= i_in.command;
            r_req.key   <= i_in.search_key[KEY_BITS-1:0];
            r_req.value <= i_in.new_value[VALUE_BITS-1:0];
        end
        if (w_exit) begin
            r_res <= n_res;
        end
        if ((r_state == S_WAIT) && w_out_free) begin
            r_out <= r_res;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept;
            if (w_exit) begin
                r_count <= n_count;
            end
            if (w_out_free) begin
                r_out_valid <= (r_state == S_WAIT);
            end
        end
    end

endmodule
